// ===== rtl/core/albf_pkg.sv =====
// Shared constants, widths and enum types for the ambient light brightness fader.
// Used by every module under rtl/core; has no dependencies of its own.
`default_nettype none

package albf_pkg;

  localparam int LVL_W     = 7;
  localparam int LIGHT_W   = 16;
  localparam int MANUAL_W  = 8;
  localparam int STEP_W    = 8;

  // Serial arithmetic widths: light x range or |diff| x step, then / threshold or steps
  localparam int MUL_A_W   = LIGHT_W;
  localparam int MUL_B_W   = STEP_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIVISOR_W = LIGHT_W;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LVL_W-1:0]    LEVEL_CEIL   = 7'd100;
  localparam logic [LVL_W-1:0]    LEVEL_FLOOR  = 7'd10;
  localparam logic [LVL_W-1:0]    RESET_LEVEL  = 7'd20;
  localparam logic [LVL_W-1:0]    RESET_MANUAL = 7'd65;
  localparam logic [LIGHT_W-1:0]  RESET_THR    = 16'd100;
  localparam logic [STEP_W-1:0]   RESET_STEPS  = 8'd10;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_MANUAL = 2'd2,
    OP_AUTO   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_MIN   = 2'd0,
    CFG_MAX   = 2'd1,
    CFG_THR   = 2'd2,
    CFG_STEPS = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/albf_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on albf_pkg for default widths.
`default_nettype none

module albf_mul #(
  parameter int AW = albf_pkg::MUL_A_W,
  parameter int BW = albf_pkg::MUL_B_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  done,
  output logic [AW+BW-1:0]      product
);
  import albf_pkg::*;

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] acc_r, acc_nxt;
  logic [PW-1:0] mcand_r, mcand_nxt;
  logic [BW-1:0] mplier_r, mplier_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = PW'(a);
      mplier_nxt = b;
      cnt_nxt    = CW'(BW);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      // add the shifted multiplicand when the current multiplier bit is set
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[PW-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[BW-1:1]};
      cnt_nxt    = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

// ===== rtl/core/albf_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on albf_pkg for default widths; divisor must be nonzero.
`default_nettype none

module albf_div #(
  parameter int NW = albf_pkg::PROD_W,
  parameter int DW = albf_pkg::DIVISOR_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);
  import albf_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] trial;
  logic          fits;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign fits   = ~trial[DW+1];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[DW-1:0] : rem_sh[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/ambient_light_brightness_fader_unit.sv =====
// Ambient light brightness fader: event decode, fade state and result register.
// Depends on albf_pkg, albf_mul and albf_div.
//
// One event is taken at a time and gives exactly one result. A light sample in
// auto mode below the threshold, and a fade tick while a fade is open, run
// through the serial multiplier and then the serial divider before the result
// is written. Every other event skips both units and goes straight to the
// result state. The next event is taken as soon as the previous one has been
// moved into the output register, which holds it until the consumer takes it.
// Configuration writes are taken in any cycle and must only be issued while no
// event is in flight.
`default_nettype none

module ambient_light_brightness_fader_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // config write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [albf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [albf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // event input
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [15:0] light_count, [23:16] manual_value, [24] auto_enable, [31:25] zero
  input  wire logic [albf_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] opcode
  input  wire logic [albf_pkg::IN_USER_W-1:0]   in_tuser,
  // result output
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [6:0] drive_level, [13:7] settled_level, [14] auto_on, [15] zero
  output logic [albf_pkg::OUT_DATA_W-1:0]       out_tdata,
  // [0] drive_update
  output logic [albf_pkg::OUT_USER_W-1:0]       out_tuser
);
  import albf_pkg::*;

  // configuration registers
  logic [LVL_W-1:0]   min_r, max_r;
  logic [LIGHT_W-1:0] thr_r;
  logic [STEP_W-1:0]  fade_r;

  // fade state
  logic [LVL_W-1:0]   start_r, start_nxt;
  logic [LVL_W-1:0]   target_r, target_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [STEP_W-1:0]  total_r, total_nxt;
  logic               auto_r, auto_nxt;
  logic [LVL_W-1:0]   manual_lvl_r, manual_lvl_nxt;

  // latched event
  op_t                op_r;
  logic               hit_r;
  logic [MANUAL_W-1:0] manual_r;
  logic               enable_r;
  logic [LVL_W-1:0]   quo_r;

  state_t             state_r, state_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  // event decode
  op_t                in_op;
  logic [LIGHT_W-1:0] in_light;
  logic [MANUAL_W-1:0] in_manual;
  logic               in_enable;
  logic               accept;
  logic               thr_hit;
  logic [LVL_W-1:0]   range;
  logic [LVL_W-1:0]   diff_mag;
  logic [STEP_W-1:0]  step_inc;
  logic [STEP_W-1:0]  total_div;
  logic               needs_mul;
  logic               commit;

  // arithmetic units
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  product;
  logic               div_done;
  logic [DIVISOR_W-1:0] divisor;
  logic [PROD_W-1:0]  quotient;

  // commit datapath
  logic [LVL_W-1:0]   lvl_map;
  logic [STEP_W-1:0]  fade_total;
  logic [STEP_W-1:0]  change;
  logic [STEP_W-1:0]  lvl_tick;
  logic [LVL_W-1:0]   manual_clamp;
  logic [LVL_W-1:0]   drive;
  logic               update;

  assign in_op     = op_t'(in_tuser);
  assign in_light  = in_tdata[LIGHT_W-1:0];
  assign in_manual = in_tdata[LIGHT_W+MANUAL_W-1:LIGHT_W];
  assign in_enable = in_tdata[LIGHT_W+MANUAL_W];
  assign accept    = in_tvalid && in_tready;

  assign thr_hit   = in_light >= thr_r;
  assign range     = (max_r > min_r) ? (max_r - min_r) : '0;
  assign diff_mag  = (target_r >= start_r) ? (target_r - start_r) : (start_r - target_r);
  assign step_inc  = step_r + STEP_W'(1);
  assign total_div = (total_r == '0) ? STEP_W'(1) : total_r;
  assign needs_mul = ((in_op == OP_SAMPLE) && auto_r && !thr_hit) ||
                     ((in_op == OP_TICK) && (start_r != target_r));

  assign mul_a = (in_op == OP_SAMPLE) ? in_light : MUL_A_W'(diff_mag);
  assign mul_b = (in_op == OP_SAMPLE) ? MUL_B_W'(range) : step_inc;
  assign divisor = (op_r == OP_SAMPLE) ? thr_r : DIVISOR_W'(total_div);

  albf_mul #(
    .AW (MUL_A_W),
    .BW (MUL_B_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (product)
  );

  albf_div #(
    .NW (PROD_W),
    .DW (DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_done),
    .dividend (product),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = needs_mul ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    mul_start = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mul_start = in_tvalid && needs_mul;
      end
      ST_MUL: ;
      ST_DIV: ;
      ST_DONE: commit = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign lvl_map      = hit_r ? max_r : (min_r + quo_r);
  assign fade_total   = (fade_r == '0) ? STEP_W'(1) : fade_r;
  // truncating signed division: negate the magnitude quotient for a downward fade
  assign change       = (target_r < start_r) ? (STEP_W'(0) - STEP_W'(quo_r)) : STEP_W'(quo_r);
  assign lvl_tick     = STEP_W'(start_r) + change;
  assign manual_clamp = (manual_r > MANUAL_W'(LEVEL_CEIL))  ? LEVEL_CEIL  :
                        (manual_r < MANUAL_W'(LEVEL_FLOOR)) ? LEVEL_FLOOR :
                        manual_r[LVL_W-1:0];

  // event effect on fade state
  always_comb begin
    start_nxt      = start_r;
    target_nxt     = target_r;
    step_nxt       = step_r;
    total_nxt      = total_r;
    auto_nxt       = auto_r;
    manual_lvl_nxt = manual_lvl_r;
    drive          = '0;
    update         = 1'b0;
    case (op_r)
      OP_SAMPLE: begin
        if (auto_r && (lvl_map != target_r)) begin
          target_nxt = lvl_map;
          step_nxt   = '0;
          total_nxt  = fade_total;
        end
      end
      OP_TICK: begin
        if (start_r != target_r) begin
          step_nxt = step_inc;
          drive    = lvl_tick[LVL_W-1:0];
          update   = 1'b1;
          if ((step_inc >= total_r) || (lvl_tick == STEP_W'(target_r))) begin
            start_nxt = target_r;
          end
        end
      end
      OP_MANUAL: begin
        manual_lvl_nxt = manual_clamp;
        if (!auto_r) begin
          target_nxt = manual_clamp;
          step_nxt   = '0;
        end
      end
      OP_AUTO: begin
        auto_nxt = enable_r;
        if (!enable_r) begin
          target_nxt = manual_lvl_r;
          step_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      hit_r    <= thr_hit;
      manual_r <= in_manual;
      enable_r <= in_enable;
    end
    if (div_done) begin
      quo_r <= quotient[LVL_W-1:0];
    end
    if (commit) begin
      out_data_r <= {1'b0, auto_nxt, start_nxt, drive};
      out_user_r <= update;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      min_r        <= RESET_LEVEL;
      max_r        <= LEVEL_CEIL;
      thr_r        <= RESET_THR;
      fade_r       <= RESET_STEPS;
      start_r      <= RESET_LEVEL;
      target_r     <= RESET_LEVEL;
      step_r       <= '0;
      total_r      <= RESET_STEPS;
      auto_r       <= 1'b1;
      manual_lvl_r <= RESET_MANUAL;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MIN:   min_r  <= cfg_data[LVL_W-1:0];
          CFG_MAX:   max_r  <= cfg_data[LVL_W-1:0];
          CFG_THR:   thr_r  <= cfg_data[LIGHT_W-1:0];
          CFG_STEPS: fade_r <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        start_r      <= start_nxt;
        target_r     <= target_nxt;
        step_r       <= step_nxt;
        total_r      <= total_nxt;
        auto_r       <= auto_nxt;
        manual_lvl_r <= manual_lvl_nxt;
      end
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// ===== rtl/core/albf_checker.sv =====
// Port-level checks for ambient_light_brightness_fader_unit, bound to the top level.
// Depends on albf_pkg for port widths.
`default_nettype none

module albf_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [albf_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [albf_pkg::OUT_USER_W-1:0] out_tuser
);
  import albf_pkg::*;

  // stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // drive level reads zero unless the item moved the level
  a_drive_zero: assert property (@(posedge clk)
    out_tvalid && !out_tuser[0] |-> out_tdata[LVL_W-1:0] == '0)
    else $error("drive level nonzero without update");

  // one event in flight: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous event in flight");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ambient_light_brightness_fader_unit albf_checker u_albf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
